/* hdl/crcw_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the word response checker.
`timescale 1ns / 1ps
package crcw_pkg;

  // Block sizing
  localparam int unsigned MAX_WORDS_DEF = 8;
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned CNT_W         = 5;   // holds counts up to 31
  localparam int unsigned IDX_W         = 3;

  // CRC-8 constants: poly 0x31, init 0xFF, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [CFG_W-1:0] WORDS_RST = 4'd2;

  // Byte position within a word
  typedef enum logic [2:0] {
    PH_HIGH  = 3'b001,
    PH_LOW   = 3'b010,
    PH_CHECK = 3'b100
  } phase_t;

  // One decoded word
  typedef struct packed {
    logic [15:0]      data_word;
    logic [IDX_W-1:0] word_index;
    logic             crc_ok;
    logic             last_word;
    logic             response_ok;
  } word_res_t;

  // MSB-first CRC-8 update over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/crcw_core.sv */
// Byte phase tracking, CRC-8 accumulation and word result formation.
`timescale 1ns / 1ps
module crcw_core #(
  parameter int unsigned MAX_WORDS = crcw_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_acc,     // a byte beat is taken this cycle
  input  logic [7:0]                 rx_byte,
  input  logic                       start_of_response,
  input  logic [crcw_pkg::CFG_W-1:0] words_cfg,
  output logic                       res_valid,    // this beat closes a word
  output crcw_pkg::word_res_t        res
);

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  crcw_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [CW-1:0]      ctr_r, ctr_nxt;
  logic               allp_r, allp_nxt;

  // State as seen after a start marker
  crcw_pkg::phase_t   ph_eff;
  logic [7:0]         crc_eff;
  logic [CW-1:0]      ctr_eff;
  logic               allp_eff;

  logic [crcw_pkg::CNT_W-1:0] cfg_ext, count, ctr_ext;
  logic [CW+crcw_pkg::IDX_W-1:0] idx_ext;
  logic [7:0]         crc_upd;
  logic               active, ok;

  // Clamp the configured word count to 1..MAX_WORDS
  always_comb begin
    cfg_ext = crcw_pkg::CNT_W'(words_cfg);
    if (words_cfg == '0) begin
      count = crcw_pkg::CNT_W'(1);
    end else if (cfg_ext > crcw_pkg::CNT_W'(MAX_WORDS)) begin
      count = crcw_pkg::CNT_W'(MAX_WORDS);
    end else begin
      count = cfg_ext;
    end
  end

  // Start marker restarts the response
  always_comb begin
    if (start_of_response) begin
      ph_eff   = crcw_pkg::PH_HIGH;
      crc_eff  = crcw_pkg::CRC_INIT;
      ctr_eff  = '0;
      allp_eff = 1'b1;
    end else begin
      ph_eff   = phase_r;
      crc_eff  = crc_r;
      ctr_eff  = ctr_r;
      allp_eff = allp_r;
    end
  end

  assign ctr_ext = crcw_pkg::CNT_W'(ctr_eff);
  assign active  = ctr_ext < count;
  assign crc_upd = crcw_pkg::crc8_byte(crc_eff, rx_byte);
  assign ok      = (crc_eff == rx_byte);
  assign idx_ext = (CW + crcw_pkg::IDX_W)'(ctr_eff);

  // Next state and result
  always_comb begin
    phase_nxt = ph_eff;
    crc_nxt   = crc_eff;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    ctr_nxt   = ctr_eff;
    allp_nxt  = allp_eff;
    res_valid = 1'b0;
    res.data_word   = {hi_r, lo_r};
    res.word_index  = idx_ext[crcw_pkg::IDX_W-1:0];
    res.crc_ok      = ok;
    res.last_word   = ((ctr_ext + crcw_pkg::CNT_W'(1)) == count);
    res.response_ok = allp_eff & ok;
    if (active) begin
      case (ph_eff)
        crcw_pkg::PH_HIGH: begin
          hi_nxt    = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = crcw_pkg::PH_LOW;
        end
        crcw_pkg::PH_LOW: begin
          lo_nxt    = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = crcw_pkg::PH_CHECK;
        end
        default: begin
          // check byte closes the word
          res_valid = 1'b1;
          allp_nxt  = allp_eff & ok;
          ctr_nxt   = ctr_eff + CW'(1);
          phase_nxt = crcw_pkg::PH_HIGH;
          crc_nxt   = crcw_pkg::CRC_INIT;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crcw_pkg::PH_HIGH;
      crc_r   <= crcw_pkg::CRC_INIT;
      hi_r    <= '0;
      lo_r    <= '0;
      ctr_r   <= '0;
      allp_r  <= 1'b1;
    end else if (byte_acc) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      ctr_r   <= ctr_nxt;
      allp_r  <= allp_nxt;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("byte phase not one-hot");

  a_ctr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    crcw_pkg::CNT_W'(ctr_r) <= crcw_pkg::CNT_W'(MAX_WORDS))
    else $error("word counter past MAX_WORDS");

  a_word_close: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && res_valid |=> phase_r == crcw_pkg::PH_HIGH && crc_r == crcw_pkg::CRC_INIT)
    else $error("word close did not rearm phase and CRC");

  a_resp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.response_ok |-> res.crc_ok)
    else $error("response ok without word crc ok");

endmodule

/* hdl/crc_word_response_checker_unit.sv */
// Top level: stream channels, word count register and result register.
`timescale 1ns / 1ps
// CRC word response checker.
// in_*  : one received response byte per beat; in_tuser flags the first byte
//         of a new response. Words are MSB, LSB, check byte (CRC-8, poly 0x31,
//         init 0xFF). Bytes past the configured word count are dropped until
//         the next start flag.
// out_* : one beat per check byte: big-endian word, its index, crc_ok,
//         response_ok and tlast on the final word of the response.
// cfg_* : words_per_response, written when cfg_wr_en is high (0 acts as 1,
//         above MAX_WORDS acts as MAX_WORDS). Write only while idle.
// Latency: the result beat is valid the cycle after its check byte is taken.
// Throughput: one byte per cycle when not stalled; the CRC update is a single
// unrolled byte step and the output register frees in the same cycle it is read.
// Stall: while out_tvalid is held by a low out_tready, the result stays put
// and in_tready drops, so no byte is taken.
// Reset (synchronous, rst_n low): byte phase, counter, CRC and pass flag
// clear, the word count returns to 2 and the result register empties.
module crc_word_response_checker_unit #(
  parameter int unsigned MAX_WORDS = crcw_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,    // [7:0] rx_byte
  input  logic                       in_tuser,    // [0] start_of_response
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,   // [15:0] data_word, [18:16] word_index, pad
  output logic [1:0]                 out_tuser,   // [0] crc_ok, [1] response_ok
  output logic                       out_tlast,   // last_word
  input  logic                       cfg_wr_en,
  input  logic [crcw_pkg::CFG_W-1:0] cfg_wr_data  // words_per_response
);

  logic [crcw_pkg::CFG_W-1:0] words_r;
  logic                       byte_acc;
  logic                       res_valid;
  crcw_pkg::word_res_t        res;
  crcw_pkg::word_res_t        out_r;
  logic                       out_vld_r, out_vld_nxt;

  // Accept whenever the result register is empty or being drained
  assign in_tready = !out_vld_r || out_tready;
  assign byte_acc  = in_tvalid && in_tready;

  // Word count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= crcw_pkg::WORDS_RST;
    end else if (cfg_wr_en) begin
      words_r <= cfg_wr_data;
    end
  end

  crcw_core #(
    .MAX_WORDS(MAX_WORDS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_acc         (byte_acc),
    .rx_byte          (in_tdata),
    .start_of_response(in_tuser),
    .words_cfg        (words_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (byte_acc && res_valid) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_r.word_index, out_r.data_word};
  assign out_tuser  = {out_r.response_ok, out_r.crc_ok};
  assign out_tlast  = out_r.last_word;

endmodule
